// ----- rtl/spd_pid_pkg.sv -----
// ----------------------------------------------------------------------------
// Speed PID package
// Shared types and constants for the velocity PID controller.
// ----------------------------------------------------------------------------
package spd_pid_pkg;

  localparam int unsigned FracBitsDef = 8;

  localparam int unsigned VelW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimitW = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // shared multiplier: signed operand A, unsigned operand B
  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 16;
  localparam int unsigned MulPW = MulAW + MulBW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_PERIOD_SEC = 3'd3,
    CFG_PERIOD_INV = 3'd4,
    CFG_SPEED_LIM  = 3'd5
  } cfg_idx_e;

  localparam logic [GainW-1:0]  GainPRst     = 16'd256;
  localparam logic [GainW-1:0]  GainIRst     = 16'd26;
  localparam logic [GainW-1:0]  GainDRst     = 16'd13;
  localparam logic [GainW-1:0]  PeriodSecRst = 16'd655;
  localparam logic [GainW-1:0]  PeriodInvRst = 16'd100;
  localparam logic [LimitW-1:0] SpeedLimRst  = 15'd2560;

  typedef struct packed {
    logic                   path_present;
    logic                   horizon_present;
    logic signed [VelW-1:0] setpoint_velocity;
    logic signed [VelW-1:0] measured_velocity;
  } in_t;

  typedef struct packed {
    logic signed [VelW-1:0] speed_command;
    logic                   clamped;
  } out_t;

  typedef struct packed {
    logic signed [MulAW-1:0] a;
    logic        [MulBW-1:0] b;
  } mul_op_t;

endpackage

// ----- rtl/spd_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed by unsigned multiply with a registered product, one per cycle.
// ----------------------------------------------------------------------------
module spd_mul (
  input  logic                                   clk_i,
  input  spd_pid_pkg::mul_op_t                   op_i,
  output logic signed [spd_pid_pkg::MulPW-1:0]   prod_o
);

  logic signed [spd_pid_pkg::MulPW-1:0] full;
  logic signed [spd_pid_pkg::MulPW-1:0] prod_q;

  // B is non-negative, so the product fits in MulAW + MulBW bits
  assign full = op_i.a * $signed({1'b0, op_i.b});

  always_ff @(posedge clk_i) begin
    prod_q <= full;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/speed_pid_step_top.sv -----
// An input transaction is taken in the idle state and runs through states M0 to M7,
// one sequencer step per cycle around the shared registered multiplier (six products,
// one sum); a waiting result holds the last step. A new item is taken only once the
// last one has left M7. Items without a trajectory are consumed with no result.
// Reset clears integral, last error and output valid, and loads register defaults.
// ----------------------------------------------------------------------------
// Speed PID step
// Velocity PID controller: error, saturating integral, derivative via
// reciprocal period, acceleration and clamped speed command.
// ----------------------------------------------------------------------------
module speed_pid_step_top #(
  parameter int unsigned FracBits = spd_pid_pkg::FracBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  spd_pid_pkg::in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output spd_pid_pkg::out_t                     out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [spd_pid_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [spd_pid_pkg::CfgDatW-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7
  } state_e;

  localparam logic signed [51:0] Sat32Max = 52'sh7FFFFFFF;
  localparam logic signed [51:0] Sat32Min = -Sat32Max - 52'sd1;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > Sat32Max) begin
      r = 32'sh7FFFFFFF;
    end else if (v < Sat32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [spd_pid_pkg::GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [spd_pid_pkg::GainW-1:0]  period_sec_q, period_inv_q;
  logic [spd_pid_pkg::LimitW-1:0] speed_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= spd_pid_pkg::GainPRst;
      gain_i_q     <= spd_pid_pkg::GainIRst;
      gain_d_q     <= spd_pid_pkg::GainDRst;
      period_sec_q <= spd_pid_pkg::PeriodSecRst;
      period_inv_q <= spd_pid_pkg::PeriodInvRst;
      speed_lim_q  <= spd_pid_pkg::SpeedLimRst;
    end else if (cfg_valid_i) begin
      case (spd_pid_pkg::cfg_idx_e'(cfg_index_i))
        spd_pid_pkg::CFG_GAIN_P:     gain_p_q     <= cfg_data_i;
        spd_pid_pkg::CFG_GAIN_I:     gain_i_q     <= cfg_data_i;
        spd_pid_pkg::CFG_GAIN_D:     gain_d_q     <= cfg_data_i;
        spd_pid_pkg::CFG_PERIOD_SEC: period_sec_q <= cfg_data_i;
        spd_pid_pkg::CFG_PERIOD_INV: period_inv_q <= cfg_data_i;
        spd_pid_pkg::CFG_SPEED_LIM:  speed_lim_q  <= cfg_data_i[spd_pid_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  state_e                   state_q;
  logic signed [16:0]       err_q, last_err_q;
  logic signed [15:0]       meas_q;
  logic signed [31:0]       integ_q, accel_q;
  logic signed [33:0]       deriv_q;
  logic signed [51:0]       acc_q;
  logic                     out_valid_q;
  spd_pid_pkg::out_t        out_q;

  spd_pid_pkg::mul_op_t                  mul_op;
  logic signed [spd_pid_pkg::MulPW-1:0]  prod;
  logic signed [spd_pid_pkg::MulPW-1:0]  prod_sh;
  logic signed [17:0]                    err_diff;
  logic signed [33:0]                    integ_sum;
  logic signed [51:0]                    acc_sum;
  logic signed [32:0]                    speed, lim, lim_neg;
  logic signed [16:0]                    tgt, err_new;

  spd_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  assign err_diff = 18'(err_q) - 18'(last_err_q);

  // operand selection for the shared multiplier
  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state_q)
      ST_M0: begin
        mul_op.a = 35'(err_q);
        mul_op.b = period_sec_q;
      end
      ST_M1: begin
        mul_op.a = 35'(err_diff);
        mul_op.b = period_inv_q;
      end
      ST_M2: begin
        mul_op.a = 35'(err_q);
        mul_op.b = gain_p_q;
      end
      ST_M3: begin
        mul_op.a = 35'(integ_q);
        mul_op.b = gain_i_q;
      end
      ST_M4: begin
        mul_op.a = 35'(deriv_q);
        mul_op.b = gain_d_q;
      end
      // kept through the output wait so the product stays in place
      ST_M6, ST_M7: begin
        mul_op.a = 35'(accel_q);
        mul_op.b = period_sec_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    tgt       = in_data_i.horizon_present ? 17'(in_data_i.setpoint_velocity) : 17'sd0;
    err_new   = tgt - 17'(in_data_i.measured_velocity);
    prod_sh   = prod >>> 16;
    integ_sum = 34'(integ_q) + 34'(prod_sh);
    acc_sum   = acc_q + 52'(prod);
    speed     = 33'(meas_q) + 33'(prod_sh);
    lim       = $signed({18'd0, speed_lim_q});
    lim_neg   = -lim;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      err_q       <= '0;
      last_err_q  <= '0;
      meas_q      <= '0;
      integ_q     <= '0;
      accel_q     <= '0;
      deriv_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_M7)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          // an item without trajectory is consumed with no result
          if (in_valid_i && in_data_i.path_present) begin
            err_q   <= err_new;
            meas_q  <= in_data_i.measured_velocity;
            state_q <= ST_M0;
          end
        end
        ST_M0: state_q <= ST_M1;
        ST_M1: begin
          integ_q    <= sat32(52'(integ_sum));
          last_err_q <= err_q;
          state_q    <= ST_M2;
        end
        ST_M2: begin
          deriv_q <= prod[33:0];
          state_q <= ST_M3;
        end
        ST_M3: begin
          acc_q   <= 52'(prod);
          state_q <= ST_M4;
        end
        ST_M4: begin
          acc_q   <= acc_sum;
          state_q <= ST_M5;
        end
        ST_M5: begin
          accel_q <= sat32(acc_sum >>> FracBits);
          state_q <= ST_M6;
        end
        ST_M6: state_q <= ST_M7;
        ST_M7: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (speed > lim) begin
              out_q.speed_command <= lim[15:0];
              out_q.clamped       <= 1'b1;
            end else if (speed < lim_neg) begin
              out_q.speed_command <= lim_neg[15:0];
              out_q.clamped       <= 1'b1;
            end else begin
              out_q.speed_command <= speed[15:0];
              out_q.clamped       <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- test/tb_speed_pid_step_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Speed PID step testbench
// Drives control ticks and register writes into the velocity PID block and
// checks each speed command against a cycle-free predictor of the loop state
// (integral, last error) and the register set, under varied handshake idling.
// ----------------------------------------------------------------------------
module tb_speed_pid_step_top;

  localparam int unsigned FracBits    = spd_pid_pkg::FracBitsDef;
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned WindTicks   = 40;
  localparam int unsigned PhaseTicks  = 180;
  localparam longint      I32Max      = 64'sd2147483647;
  localparam longint      I32Min      = -64'sd2147483647 - 64'sd1;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  spd_pid_pkg::in_t                 in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  spd_pid_pkg::out_t                out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [spd_pid_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [spd_pid_pkg::CfgDatW-1:0]  cfg_data = '0;

  logic                in_taken = 1'b0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         cycles = 0;
  int unsigned         n_ticks = 0;
  int unsigned         n_traj = 0;
  int unsigned         n_results = 0;
  int unsigned         n_mismatch = 0;
  int unsigned         n_settings = 0;

  spd_pid_pkg::in_t    tick_q[$];
  spd_pid_pkg::out_t   cmd_expected_q[$];

  // register copies and loop state of the predictor
  longint gain_p_m     = longint'(spd_pid_pkg::GainPRst);
  longint gain_i_m     = longint'(spd_pid_pkg::GainIRst);
  longint gain_d_m     = longint'(spd_pid_pkg::GainDRst);
  longint period_sec_m = longint'(spd_pid_pkg::PeriodSecRst);
  longint period_inv_m = longint'(spd_pid_pkg::PeriodInvRst);
  longint speed_lim_m  = longint'(spd_pid_pkg::SpeedLimRst);
  longint integ_m      = 0;
  longint last_err_m   = 0;

  speed_pid_step_top #(
    .FracBits(FracBits)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat32(input longint v);
    if (v > I32Max) return I32Max;
    if (v < I32Min) return I32Min;
    return v;
  endfunction

  // one control tick; advances integral and last error
  function automatic spd_pid_pkg::out_t speed_cmd_predict(input spd_pid_pkg::in_t tk);
    longint            tgt, meas, err, deriv, accel, spd;
    spd_pid_pkg::out_t res;
    tgt  = tk.horizon_present ? longint'($signed(tk.setpoint_velocity)) : 64'sd0;
    meas = longint'($signed(tk.measured_velocity));
    err  = tgt - meas;
    integ_m    = sat32(integ_m + ((err * period_sec_m) >>> 16));
    deriv      = (err - last_err_m) * period_inv_m;
    last_err_m = err;
    accel = gain_p_m * err + gain_i_m * integ_m + gain_d_m * deriv;
    accel = sat32(accel >>> FracBits);
    spd   = meas + ((accel * period_sec_m) >>> 16);
    res.clamped = 1'b0;
    if (spd > speed_lim_m) begin
      spd = speed_lim_m;
      res.clamped = 1'b1;
    end else if (spd < -speed_lim_m) begin
      spd = -speed_lim_m;
      res.clamped = 1'b1;
    end
    res.speed_command = 16'(spd);
    return res;
  endfunction

  function automatic spd_pid_pkg::in_t tick(input int p, input int h, input int tgt,
                                            input int meas);
    spd_pid_pkg::in_t tk;
    tk.path_present      = 1'(p);
    tk.horizon_present   = 1'(h);
    tk.setpoint_velocity = 16'(tgt);
    tk.measured_velocity = 16'(meas);
    return tk;
  endfunction

  function automatic logic [15:0] extreme_vel();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic spd_pid_pkg::in_t rand_tick();
    spd_pid_pkg::in_t tk;
    int               meas;
    tk.path_present    = ($urandom_range(99) < 90);
    tk.horizon_present = ($urandom_range(99) < 85);
    meas = int'($urandom_range(6000)) - 3000;
    case ($urandom_range(3))
      0: begin
        tk.setpoint_velocity = 16'($urandom);
        tk.measured_velocity = 16'($urandom);
      end
      1: begin
        // tracking near the set point: the usual operating region
        tk.measured_velocity = 16'(meas);
        tk.setpoint_velocity = 16'(meas + int'($urandom_range(1024)) - 512);
      end
      2: begin
        tk.setpoint_velocity = extreme_vel();
        tk.measured_velocity = extreme_vel();
      end
      default: begin
        tk.setpoint_velocity = 16'($urandom);
        tk.measured_velocity = 16'(meas);
      end
    endcase
    return tk;
  endfunction

  function automatic logic [15:0] pick_reg(input int unsigned lo, input int unsigned hi,
                                           input int unsigned typ_hi);
    case ($urandom_range(3))
      0: return 16'(lo);
      1: return 16'(hi);
      2: return 16'($urandom_range(hi, lo));
      default: return 16'($urandom_range(typ_hi, lo));
    endcase
  endfunction

  task automatic cfg_write(input spd_pid_pkg::cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      spd_pid_pkg::CFG_GAIN_P:     gain_p_m     = longint'(val);
      spd_pid_pkg::CFG_GAIN_I:     gain_i_m     = longint'(val);
      spd_pid_pkg::CFG_GAIN_D:     gain_d_m     = longint'(val);
      spd_pid_pkg::CFG_PERIOD_SEC: period_sec_m = longint'(val);
      spd_pid_pkg::CFG_PERIOD_INV: period_inv_m = longint'(val);
      spd_pid_pkg::CFG_SPEED_LIM:  speed_lim_m  = longint'(val[spd_pid_pkg::LimitW-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(input logic [15:0] gp, input logic [15:0] gi, input logic [15:0] gd,
                           input logic [15:0] ps, input logic [15:0] pinv,
                           input logic [15:0] lim);
    cfg_write(spd_pid_pkg::CFG_GAIN_P, gp);
    cfg_write(spd_pid_pkg::CFG_GAIN_I, gi);
    cfg_write(spd_pid_pkg::CFG_GAIN_D, gd);
    cfg_write(spd_pid_pkg::CFG_PERIOD_SEC, ps);
    cfg_write(spd_pid_pkg::CFG_PERIOD_INV, pinv);
    cfg_write(spd_pid_pkg::CFG_SPEED_LIM, lim);
    n_settings++;
  endtask

  // block is idle once nothing is queued, offered or outstanding
  task automatic drain();
    do @(posedge clk); while (tick_q.size() != 0 || in_valid || cmd_expected_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin : mon
    spd_pid_pkg::out_t exp_r;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n_ticks++;
        if (in_data.path_present) begin
          n_traj++;
          cmd_expected_q.push_back(speed_cmd_predict(in_data));
        end
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (cmd_expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= ReportMax)
            $display("unexpected result: cmd=%0d clamp=%0b",
                     $signed(out_data.speed_command), out_data.clamped);
        end else begin
          exp_r = cmd_expected_q.pop_front();
          if (exp_r.speed_command !== out_data.speed_command ||
              exp_r.clamped !== out_data.clamped) begin
            n_mismatch++;
            if (n_mismatch <= ReportMax)
              $display("result %0d: cmd exp %0d got %0d, clamp exp %0b got %0b",
                       n_results, $signed(exp_r.speed_command),
                       $signed(out_data.speed_command), exp_r.clamped, out_data.clamped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    send_pct = '{0, 64, 0, 17};
    recv_pct = '{0, 0, 64, 17};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values: basic tracking, full-scale error, no trajectory, no horizon
    tick_q.push_back(tick(1, 1, 0, 0));
    tick_q.push_back(tick(1, 1, 32767, -32768));
    tick_q.push_back(tick(1, 1, -32768, 32767));
    tick_q.push_back(tick(0, 1, 1000, 200));
    tick_q.push_back(tick(1, 0, 12345, 256));
    tick_q.push_back(tick(1, 1, 2560, 0));
    tick_q.push_back(tick(1, 1, -2560, -2000));
    drain();

    // everything at full scale: acceleration sum saturates
    apply_cfg(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
    tick_q.push_back(tick(1, 1, 32767, -32768));
    tick_q.push_back(tick(1, 1, -32768, 32767));
    tick_q.push_back(tick(1, 1, 0, 0));
    tick_q.push_back(tick(1, 0, -5, 100));
    drain();

    // zero speed limit: command forced to zero
    apply_cfg(spd_pid_pkg::GainPRst, spd_pid_pkg::GainIRst, spd_pid_pkg::GainDRst,
              spd_pid_pkg::PeriodSecRst, spd_pid_pkg::PeriodInvRst, 16'd0);
    tick_q.push_back(tick(1, 1, 0, 0));
    tick_q.push_back(tick(1, 1, 500, 100));
    tick_q.push_back(tick(1, 1, -500, 100));
    drain();

    // zero period registers
    apply_cfg(spd_pid_pkg::GainPRst, spd_pid_pkg::GainIRst, spd_pid_pkg::GainDRst,
              16'd0, 16'd0, 16'(spd_pid_pkg::SpeedLimRst));
    tick_q.push_back(tick(1, 1, 1000, 300));
    tick_q.push_back(tick(1, 1, -1000, -300));
    tick_q.push_back(tick(0, 0, 0, 0));
    drain();

    // zero gains: command equals measured velocity, clamped to the speed limit
    apply_cfg(16'd0, 16'd0, 16'd0, spd_pid_pkg::PeriodSecRst, spd_pid_pkg::PeriodInvRst,
              16'(spd_pid_pkg::SpeedLimRst));
    tick_q.push_back(tick(1, 1, 100, 3000));
    tick_q.push_back(tick(1, 1, 100, -200));
    drain();

    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = send_pct[m];
      recv_stall_pct = recv_pct[m];
      for (int s = 0; s < 2; s++) begin
        apply_cfg(pick_reg(0, 65535, 512), pick_reg(0, 65535, 64), pick_reg(0, 65535, 64),
                  pick_reg(1, 65535, 2000), pick_reg(1, 65535, 200),
                  pick_reg(0, 32767, 4096));
        for (int n = 0; n < PhaseTicks; n++)
          tick_q.push_back(rand_tick());
        drain();
      end
    end

    // run of full-scale error to wind the integral up, then unwind
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_cfg(spd_pid_pkg::GainPRst, spd_pid_pkg::GainIRst, spd_pid_pkg::GainDRst,
              16'hffff, spd_pid_pkg::PeriodInvRst, 16'h7fff);
    for (int n = 0; n < WindTicks; n++)
      tick_q.push_back(tick(1, 1, 32767, -32768));
    drain();
    for (int n = 0; n < 8; n++)
      tick_q.push_back(tick(1, 1, -32768, 32767));
    for (int n = 0; n < 8; n++)
      tick_q.push_back(rand_tick());
    drain();

    $display("Ran %0d control ticks (%0d with a trajectory), %0d speed commands checked,",
             n_ticks, n_traj, n_results);
    $display("over %0d register settings, four idling patterns and integral wind-up.",
             n_settings);
    if (n_mismatch == 0 && cmd_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
